// ===== hw/rtl/sahj_pkg.sv =====
// shared types and constants of the stepper axis supervisor
package sahj_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SPEED_W    = 20;
  localparam int BACKOFF_W  = 16;
  localparam int FULL_W     = 13;
  localparam int VALUE_W    = 32;
  localparam int PROD_W     = FULL_W + SPEED_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int QDEPTH     = 4;
  localparam int QCNT_W     = $clog2(QDEPTH) + 1;

  // register reset values
  localparam logic                 RST_HOME_TOWARD_MIN = 1'b1;
  localparam logic [SPEED_W-1:0]   RST_HOMING_SPEED    = SPEED_W'(2000);
  localparam logic [BACKOFF_W-1:0] RST_BACKOFF_STEPS   = BACKOFF_W'(200);
  localparam logic [SPEED_W-1:0]   RST_DEFAULT_ACCEL   = SPEED_W'(10000);
  localparam logic [FULL_W-1:0]    RST_JOG_FULL_COUNTS = FULL_W'(40);
  localparam logic [SPEED_W-1:0]   RST_JOG_MAX_SPEED   = SPEED_W'(4000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOME_TOWARD_MIN = 3'd0,
    CFG_HOMING_SPEED    = 3'd1,
    CFG_BACKOFF_STEPS   = 3'd2,
    CFG_DEFAULT_ACCEL   = 3'd3,
    CFG_JOG_FULL_COUNTS = 3'd4,
    CFG_JOG_MAX_SPEED   = 3'd5
  } sahj_cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_BEGIN = 2'd2,
    OP_END   = 2'd3
  } sahj_op_t;

  typedef enum logic [3:0] {
    CMD_SET_SPEED  = 4'd0,
    CMD_SET_ACCEL  = 4'd1,
    CMD_RUN_FWD    = 4'd2,
    CMD_RUN_BACK   = 4'd3,
    CMD_MOVE_TO    = 4'd4,
    CMD_DECEL_STOP = 4'd5,
    CMD_STOP_ZERO  = 4'd6,
    CMD_STOP_HOLD  = 4'd7,
    CMD_CLEAR_ENC  = 4'd8
  } sahj_command_t;

  typedef enum logic [1:0] {
    PH_DRIVING = 2'd0,
    PH_BACKING = 2'd1,
    PH_DONE    = 2'd2
  } sahj_phase_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_JOG  = 6'b010000,
    ST_EMIT = 6'b100000
  } sahj_state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic                     min_limit_hit;
    logic                     max_limit_hit;
    logic signed [VALUE_W-1:0] encoder_count;
    logic                     motor_running;
    logic signed [1:0]        motor_direction;
    logic signed [VALUE_W-1:0] move_target;
    logic [SPEED_W-1:0]       move_speed;
    logic [SPEED_W-1:0]       move_accel;
    logic                     stop_now;
  } sahj_item_t;

  typedef struct packed {
    logic [3:0]                command;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      is_homed;
    logic                      in_programmed_mode;
  } sahj_result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic jog;
    logic emit;
  } sahj_ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic jog_en;
    logic div_last;
    logic queue_empty;
  } sahj_ctrl_sts_t;

endpackage

// ===== hw/rtl/sahj_if.sv =====
// valid/ready channel interfaces for items and commands
interface sahj_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic                     min_limit_hit;
  logic                     max_limit_hit;
  logic signed [31:0]       encoder_count;
  logic                     motor_running;
  logic signed [1:0]        motor_direction;
  logic signed [31:0]       move_target;
  logic [19:0]              move_speed;
  logic [19:0]              move_accel;
  logic                     stop_now;

  modport source (
    output valid, opcode, min_limit_hit, max_limit_hit, encoder_count, motor_running,
           motor_direction, move_target, move_speed, move_accel, stop_now,
    input  ready
  );
  modport sink (
    input  valid, opcode, min_limit_hit, max_limit_hit, encoder_count, motor_running,
           motor_direction, move_target, move_speed, move_accel, stop_now,
    output ready
  );
endinterface

interface sahj_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] value;
  logic               last;
  logic               is_homed;
  logic               in_programmed_mode;

  modport source (
    output valid, command, value, last, is_homed, in_programmed_mode,
    input  ready
  );
  modport sink (
    input  valid, command, value, last, is_homed, in_programmed_mode,
    output ready
  );
endinterface

// ===== hw/rtl/sahj_ctrl.sv =====
// sequencing state machine of the stepper axis supervisor
module sahj_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sahj_pkg::sahj_ctrl_sts_t sts,
  output sahj_pkg::sahj_ctrl_cmd_t cmd
);

  sahj_pkg::sahj_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sahj_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sahj_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = sahj_pkg::ST_EVAL;
      end
      sahj_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.jog_en ? sahj_pkg::ST_MUL : sahj_pkg::ST_EMIT;
      end
      sahj_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sahj_pkg::ST_DIV;
      end
      sahj_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = sahj_pkg::ST_JOG;
      end
      sahj_pkg::ST_JOG: begin
        cmd.jog    = 1'b1;
        state_next = sahj_pkg::ST_EMIT;
      end
      sahj_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.queue_empty) state_next = sahj_pkg::ST_IDLE;
      end
      default: begin
        state_next = sahj_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sahj_dp.sv =====
// datapath: registers, homing and limit logic, jog scaling divider, command queue
module sahj_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sahj_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sahj_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sahj_pkg::sahj_item_t                 item,
  input  sahj_pkg::sahj_ctrl_cmd_t             cmd,
  output sahj_pkg::sahj_ctrl_sts_t             sts,
  output sahj_pkg::sahj_result_t               res,
  output logic                                 res_valid,
  input  logic                                 res_ready
);

  localparam int CW1 = COUNT_WIDTH + 1;
  localparam int VW  = sahj_pkg::VALUE_W;
  localparam int SW  = sahj_pkg::SPEED_W;
  localparam int FW  = sahj_pkg::FULL_W;
  localparam int PW  = sahj_pkg::PROD_W;
  localparam int QD  = sahj_pkg::QDEPTH;

  // configuration registers
  logic                              home_toward_min;
  logic [SW-1:0]                     homing_speed;
  logic [sahj_pkg::BACKOFF_W-1:0]    backoff_steps;
  logic [SW-1:0]                     default_accel;
  logic [FW-1:0]                     jog_full_counts;
  logic [SW-1:0]                     jog_max_speed;

  // supervisor state
  sahj_pkg::sahj_phase_t             phase, phase_next;
  logic                              homed, homed_next;
  logic                              programmed, programmed_next;
  logic signed [1:0]                 last_jog_sign;
  logic [SW-1:0]                     last_jog_rate;

  sahj_pkg::sahj_item_t              item_q;

  // jog scaling
  logic [FW-1:0]                     jog_mag, ev_mag;
  logic signed [1:0]                 jog_sign, ev_sign;
  logic [PW-1:0]                     prod;
  logic [FW-1:0]                     rem;
  logic [FW:0]                       rem_sh;
  logic                              rem_ge;
  logic [sahj_pkg::DIV_CNT_W-1:0]    div_cnt;
  logic [SW-1:0]                     jog_rate;
  logic                              jog_change;

  // command queue
  sahj_pkg::sahj_command_t           q_cmd [QD];
  logic [VW-1:0]                     q_val [QD];
  logic [sahj_pkg::QCNT_W-1:0]       q_cnt;
  logic                              pop;

  // evaluation of one item
  sahj_pkg::sahj_command_t           ev_cmd [QD];
  logic [VW-1:0]                     ev_val [QD];
  logic [sahj_pkg::QCNT_W-1:0]       ev_n;
  logic                              ev_clear_jog;
  logic                              ev_cleared;
  logic                              ev_hstop;
  logic                              ev_jog_en;
  logic                              home_hit;
  logic                              dir_neg, dir_pos;

  logic signed [CW1-1:0]             cnt_raw, full_pos, full_neg, cnt_clamp, cnt_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_toward_min <= sahj_pkg::RST_HOME_TOWARD_MIN;
      homing_speed    <= sahj_pkg::RST_HOMING_SPEED;
      backoff_steps   <= sahj_pkg::RST_BACKOFF_STEPS;
      default_accel   <= sahj_pkg::RST_DEFAULT_ACCEL;
      jog_full_counts <= sahj_pkg::RST_JOG_FULL_COUNTS;
      jog_max_speed   <= sahj_pkg::RST_JOG_MAX_SPEED;
    end else if (cfg_we) begin
      unique case (sahj_pkg::sahj_cfg_idx_t'(cfg_index))
        sahj_pkg::CFG_HOME_TOWARD_MIN: home_toward_min <= cfg_data[0];
        sahj_pkg::CFG_HOMING_SPEED:    homing_speed    <= cfg_data[SW-1:0];
        sahj_pkg::CFG_BACKOFF_STEPS:   backoff_steps   <= cfg_data[sahj_pkg::BACKOFF_W-1:0];
        sahj_pkg::CFG_DEFAULT_ACCEL:   default_accel   <= cfg_data[SW-1:0];
        sahj_pkg::CFG_JOG_FULL_COUNTS: jog_full_counts <= cfg_data[FW-1:0];
        sahj_pkg::CFG_JOG_MAX_SPEED:   jog_max_speed   <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= item;
  end

  // homing, limit cutoff and mode changes
  assign home_hit = home_toward_min ? item_q.min_limit_hit : item_q.max_limit_hit;
  assign dir_neg  = item_q.motor_direction[1];
  assign dir_pos  = !item_q.motor_direction[1] && item_q.motor_direction[0];

  always_comb begin
    ev_cmd          = '{default: sahj_pkg::CMD_SET_SPEED};
    ev_val          = '{default: '0};
    ev_n            = '0;
    phase_next      = phase;
    homed_next      = homed;
    programmed_next = programmed;
    ev_clear_jog    = 1'b0;
    ev_cleared      = 1'b0;
    ev_hstop        = 1'b0;
    unique case (sahj_pkg::sahj_op_t'(item_q.opcode))
      sahj_pkg::OP_START: begin
        ev_cmd[0] = sahj_pkg::CMD_SET_ACCEL;
        ev_val[0] = VW'(default_accel);
        ev_cmd[1] = sahj_pkg::CMD_CLEAR_ENC;
        ev_cmd[2] = sahj_pkg::CMD_SET_SPEED;
        ev_val[2] = VW'(homing_speed);
        ev_cmd[3] = home_toward_min ? sahj_pkg::CMD_RUN_BACK : sahj_pkg::CMD_RUN_FWD;
        ev_n      = sahj_pkg::QCNT_W'(4);
      end
      sahj_pkg::OP_BEGIN: begin
        if (homed) begin
          programmed_next = 1'b1;
          ev_cmd[0] = sahj_pkg::CMD_SET_SPEED;
          ev_val[0] = VW'(item_q.move_speed);
          ev_cmd[1] = sahj_pkg::CMD_SET_ACCEL;
          ev_val[1] = VW'(item_q.move_accel);
          ev_cmd[2] = sahj_pkg::CMD_MOVE_TO;
          ev_val[2] = item_q.move_target;
          ev_n      = sahj_pkg::QCNT_W'(3);
        end
      end
      sahj_pkg::OP_END: begin
        if (item_q.stop_now) begin
          ev_cmd[0] = sahj_pkg::CMD_STOP_HOLD;
          ev_n      = sahj_pkg::QCNT_W'(1);
        end
        ev_cmd[ev_n[1:0]] = sahj_pkg::CMD_SET_ACCEL;
        ev_val[ev_n[1:0]] = VW'(default_accel);
        ev_n              = ev_n + 1'b1;
        ev_cmd[ev_n[1:0]] = sahj_pkg::CMD_CLEAR_ENC;
        ev_n              = ev_n + 1'b1;
        ev_clear_jog      = 1'b1;
        programmed_next   = 1'b0;
      end
      sahj_pkg::OP_TICK: begin
        if (!homed) begin
          case (phase)
            sahj_pkg::PH_DRIVING: begin
              if (home_hit) begin
                ev_cmd[0]  = sahj_pkg::CMD_STOP_ZERO;
                ev_cmd[1]  = sahj_pkg::CMD_MOVE_TO;
                ev_val[1]  = home_toward_min ? VW'(backoff_steps) : (VW'(0) - VW'(backoff_steps));
                ev_n       = sahj_pkg::QCNT_W'(2);
                phase_next = sahj_pkg::PH_BACKING;
                ev_hstop   = 1'b1;
              end
            end
            sahj_pkg::PH_BACKING: begin
              if (!item_q.motor_running) begin
                ev_cmd[0]  = sahj_pkg::CMD_CLEAR_ENC;
                ev_n       = sahj_pkg::QCNT_W'(1);
                ev_cleared = 1'b1;
                phase_next = sahj_pkg::PH_DONE;
                homed_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (!ev_hstop && ((item_q.min_limit_hit && dir_neg) ||
                          (item_q.max_limit_hit && dir_pos))) begin
          ev_cmd[ev_n[1:0]] = sahj_pkg::CMD_STOP_HOLD;
          ev_n              = ev_n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign ev_jog_en = (sahj_pkg::sahj_op_t'(item_q.opcode) == sahj_pkg::OP_TICK) &&
                     !programmed_next && homed_next;

  // clamp the knob count to +-full scale; a cleared count reads as zero
  always_comb begin
    cnt_raw   = ev_cleared ? '0 : {item_q.encoder_count[COUNT_WIDTH-1],
                                   item_q.encoder_count[COUNT_WIDTH-1:0]};
    full_pos  = CW1'(signed'({1'b0, jog_full_counts}));
    full_neg  = -full_pos;
    cnt_clamp = cnt_raw;
    if (cnt_raw > full_pos) cnt_clamp = full_pos;
    if (cnt_raw < full_neg) cnt_clamp = full_neg;
    cnt_abs   = cnt_clamp[CW1-1] ? -cnt_clamp : cnt_clamp;
    ev_mag    = cnt_abs[FW-1:0];
    if (cnt_clamp[CW1-1])       ev_sign = 2'sb11;
    else if (cnt_clamp != '0)   ev_sign = 2'sb01;
    else                        ev_sign = 2'sb00;
  end

  // restoring divider, one quotient bit a cycle; quotient builds in the low end of prod
  assign rem_sh = {rem, prod[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, jog_full_counts};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      jog_mag  <= ev_mag;
      jog_sign <= ev_sign;
    end
    if (cmd.mul) begin
      prod    <= PW'(jog_mag) * PW'(jog_max_speed);
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? FW'(rem_sh - {1'b0, jog_full_counts}) : rem_sh[FW-1:0];
      prod    <= {prod[PW-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // zero magnitude covers a zero full-scale setting
  assign jog_rate   = (jog_mag == '0) ? '0 : prod[SW-1:0];
  assign jog_change = (jog_sign != last_jog_sign) || (jog_rate != last_jog_rate);

  assign pop = cmd.emit && (q_cnt != '0) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sahj_pkg::PH_DRIVING;
      homed         <= 1'b0;
      programmed    <= 1'b0;
      last_jog_sign <= '0;
      last_jog_rate <= '0;
      q_cnt         <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.eval) begin
        phase      <= phase_next;
        homed      <= homed_next;
        programmed <= programmed_next;
        q_cmd      <= ev_cmd;
        q_val      <= ev_val;
        q_cnt      <= ev_n;
        if (ev_clear_jog) begin
          last_jog_sign <= '0;
          last_jog_rate <= '0;
        end
      end
      if (cmd.jog && jog_change) begin
        last_jog_sign <= jog_sign;
        last_jog_rate <= jog_rate;
        if (jog_rate == '0) begin
          q_cmd[q_cnt[1:0]] <= sahj_pkg::CMD_DECEL_STOP;
          q_val[q_cnt[1:0]] <= '0;
          q_cnt             <= q_cnt + 1'b1;
        end else begin
          q_cmd[q_cnt[1:0]]        <= sahj_pkg::CMD_SET_SPEED;
          q_val[q_cnt[1:0]]        <= VW'(jog_rate);
          q_cmd[q_cnt[1:0] + 2'd1] <= jog_sign[1] ? sahj_pkg::CMD_RUN_BACK
                                                  : sahj_pkg::CMD_RUN_FWD;
          q_val[q_cnt[1:0] + 2'd1] <= '0;
          q_cnt                    <= q_cnt + 2'd2;
        end
      end
      if (pop) begin
        for (int i = 0; i < QD - 1; i++) begin
          q_cmd[i] <= q_cmd[i+1];
          q_val[i] <= q_val[i+1];
        end
        q_cnt     <= q_cnt - 1'b1;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.command            <= q_cmd[0];
      res.value              <= q_val[0];
      res.last               <= (q_cnt == sahj_pkg::QCNT_W'(1));
      res.is_homed           <= homed;
      res.in_programmed_mode <= programmed;
    end
  end

  assign sts.jog_en      = ev_jog_en;
  assign sts.div_last    = (div_cnt == sahj_pkg::DIV_CNT_W'(sahj_pkg::DIV_STEPS - 1));
  assign sts.queue_empty = (q_cnt == '0);

endmodule

// ===== hw/rtl/stepper_axis_homing_jog_supervisor_core.sv =====
// top level of the stepper axis homing and jog supervisor
// an accepted item is evaluated and its commands (0 to 4) queued, then drained in order
// a jog tick (homed, manual) adds a multiply, the restoring-divider steps and a compare
// the drain holds while the output register is stalled; one item in work at a time: the next
// is accepted only after the sequencer has drained every queued command and returned to idle
// synchronous active-high reset restores register defaults, homing to driving, manual mode
module stepper_axis_homing_jog_supervisor_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  sahj_in_if.sink                         in_ch,
  sahj_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sahj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sahj_pkg::CFG_DATA_W-1:0] cfg_data
);

  sahj_pkg::sahj_item_t     item;
  sahj_pkg::sahj_result_t   res;
  sahj_pkg::sahj_ctrl_cmd_t ctrl_cmd;
  sahj_pkg::sahj_ctrl_sts_t ctrl_sts;
  logic                     res_valid;

  // gather the incoming transaction payload
  assign item.opcode          = in_ch.opcode;
  assign item.min_limit_hit   = in_ch.min_limit_hit;
  assign item.max_limit_hit   = in_ch.max_limit_hit;
  assign item.encoder_count   = in_ch.encoder_count;
  assign item.motor_running   = in_ch.motor_running;
  assign item.motor_direction = in_ch.motor_direction;
  assign item.move_target     = in_ch.move_target;
  assign item.move_speed      = in_ch.move_speed;
  assign item.move_accel      = in_ch.move_accel;
  assign item.stop_now        = in_ch.stop_now;

  // sequencer: idle, evaluate, multiply, divide, jog compare, drain
  sahj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (ctrl_sts),
    .cmd      (ctrl_cmd)
  );

  // registers, supervisor state, divider and command queue
  sahj_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (ctrl_cmd),
    .sts       (ctrl_sts),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_ch.ready)
  );

  // outgoing command transactions straight from the output register
  assign out_ch.valid              = res_valid;
  assign out_ch.command            = res.command;
  assign out_ch.value              = res.value;
  assign out_ch.last               = res.last;
  assign out_ch.is_homed           = res.is_homed;
  assign out_ch.in_programmed_mode = res.in_programmed_mode;

`ifndef SYNTHESIS
  // one item at a time: no second acceptance right after one
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  // more commands of the item still queued, so no new item may enter
  a_no_accept_midstream : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.last) |-> !in_ch.ready)
    else $error("input ready while commands of the current item remain");

  // programmed mode is only reachable once homed
  a_prog_needs_homed : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.in_programmed_mode) |-> out_ch.is_homed)
    else $error("programmed mode reported without homing");
`endif

endmodule
